@@ hdl/bls_pkg.sv @@
// Shared widths, codes and the command record for the line stepper.
package bls_pkg;

  localparam int COORD_BITS = 12;
  localparam int STR_BITS   = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [STR_BITS-1:0]        str_inc_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Classified transaction handed from the front end to the back end.
  typedef struct packed {
    logic   is_start;
    logic   steep;
    logic   major_down;
    logic   minor_down;
    coord_t major_start;
    coord_t minor_start;
    coord_t major_end;
    coord_t d_major;
    coord_t d_minor;
  } cmd_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hdl/bls_in_if.sv @@
// Input channel: start / step transactions with valid-ready handshake.
interface bls_in_if
  import bls_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   mode;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

@@ hdl/bls_out_if.sv @@
// Result channel: plotted pixel transactions with valid-ready handshake.
interface bls_out_if
  import bls_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

@@ hdl/bresenham_line_stepper.sv @@
// Top level of the midpoint line stepper: front end, command queue, back end.
//
// Midpoint line rasterizer, one pixel per step transaction, endpoints
// inclusive. A start transaction (mode 0) loads both endpoints and gives no
// pixel; it abandons any line in progress. Each step transaction (mode 1)
// gives the next pixel and flags the final one with last; a step with no line
// in progress is swallowed. Rate: one transaction per clock sustained while
// the output keeps up, set by the back end's single decision add and compare
// per pixel. A two-entry queue sits between the front end (endpoint compare,
// axis swap, abs deltas) and the back end, and an output register parts the
// back end from the result channel, so input is taken while a pixel waits.
module bresenham_line_stepper
  import bls_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bls_in_if.sink    in_ch,
  bls_out_if.source out_ch
);

  logic    push, pop;
  cmd_t    push_cmd, head;
  q_stat_t q_stat;

  // classify: endpoint deltas, steepness, directions
  bls_front u_front (
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples classification from stepping
  bls_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // line state and per-pixel stepping
  bls_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ hdl/bls_front.sv @@
// Front end: accepts transactions and classifies them into line commands.
module bls_front
  import bls_pkg::*;
(
  bls_in_if.sink in_ch,
  input  q_stat_t q_stat,
  output logic    push,
  output cmd_t    push_cmd
);

  logic   x_lt, y_lt;
  coord_t adx, ady;
  logic   steep;

  assign x_lt  = in_ch.start_x < in_ch.end_x;
  assign y_lt  = in_ch.start_y < in_ch.end_y;
  assign adx   = x_lt ? (in_ch.end_x - in_ch.start_x) : (in_ch.start_x - in_ch.end_x);
  assign ady   = y_lt ? (in_ch.end_y - in_ch.start_y) : (in_ch.start_y - in_ch.end_y);
  assign steep = ady > adx;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    push_cmd.is_start = (in_ch.mode == MODE_START);
    push_cmd.steep    = steep;
    if (steep) begin
      push_cmd.major_down  = !y_lt;
      push_cmd.minor_down  = !x_lt;
      push_cmd.major_start = in_ch.start_y;
      push_cmd.minor_start = in_ch.start_x;
      push_cmd.major_end   = in_ch.end_y;
      push_cmd.d_major     = ady;
      push_cmd.d_minor     = adx;
    end else begin
      push_cmd.major_down  = !x_lt;
      push_cmd.minor_down  = !y_lt;
      push_cmd.major_start = in_ch.start_x;
      push_cmd.minor_start = in_ch.start_y;
      push_cmd.major_end   = in_ch.end_x;
      push_cmd.d_major     = adx;
      push_cmd.d_minor     = ady;
    end
  end

endmodule

@@ hdl/bls_queue.sv @@
// Two-entry command queue between front end and back end.
module bls_queue
  import bls_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign head         = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hdl/bls_back.sv @@
// Back end: holds the line state, steps the decision value, drives pixels.
module bls_back
  import bls_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    head,
  input  q_stat_t q_stat,
  output logic    pop,
  bls_out_if.source out_ch
);

  logic     active_r, steep_r, major_down_r, minor_down_r;
  coord_t   major_pos_r, minor_pos_r, major_end_r;
  dec_t     dec_r;
  str_inc_t str_inc_r;
  dec_t     diag_inc_r;

  logic     out_valid_r, out_last_r;
  coord_t   out_x_r, out_y_r;

  logic     out_free, emit, is_last, go_diag;
  logic signed [COORD_BITS:0] d_diff;

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = !q_stat.empty && (head.is_start || out_free);
  assign emit     = pop && !head.is_start && active_r;
  assign is_last  = (major_pos_r == major_end_r);
  assign go_diag  = !(dec_r[DEC_BITS-1] || (dec_r == '0));
  assign d_diff   = $signed({1'b0, head.d_minor}) - $signed({1'b0, head.d_major});

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pixel_x = out_x_r;
  assign out_ch.pixel_y = out_y_r;
  assign out_ch.last    = out_last_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r    <= steep_r ? minor_pos_r : major_pos_r;
      out_y_r    <= steep_r ? major_pos_r : minor_pos_r;
      out_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      active_r     <= 1'b0;
      steep_r      <= 1'b0;
      major_down_r <= 1'b0;
      minor_down_r <= 1'b0;
      major_pos_r  <= '0;
      minor_pos_r  <= '0;
      major_end_r  <= '0;
      dec_r        <= '0;
      str_inc_r    <= '0;
      diag_inc_r   <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (pop && head.is_start) begin
        active_r     <= 1'b1;
        steep_r      <= head.steep;
        major_down_r <= head.major_down;
        minor_down_r <= head.minor_down;
        major_pos_r  <= head.major_start;
        minor_pos_r  <= head.minor_start;
        major_end_r  <= head.major_end;
        str_inc_r    <= {1'b0, head.d_minor, 1'b0};
        diag_inc_r   <= {d_diff[COORD_BITS], d_diff, 1'b0};
        dec_r        <= $signed({2'b00, head.d_minor, 1'b0}) -
                        $signed({3'b000, head.d_major});
      end else if (emit) begin
        if (is_last) begin
          active_r <= 1'b0;
        end else begin
          if (go_diag) begin
            minor_pos_r <= minor_down_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
            dec_r       <= dec_r + diag_inc_r;
          end else begin
            dec_r <= dec_r + $signed({1'b0, str_inc_r});
          end
          major_pos_r <= major_down_r ? (major_pos_r - 1'b1) : (major_pos_r + 1'b1);
        end
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
// Testbench for the midpoint line stepper: directed table, random lines, self-checking.
`timescale 1ns / 100ps

module tb_top;
  import bls_pkg::*;

  // One plotted pixel as it leaves the block.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // One row of stimulus. Rows with known set carry a hand-typed outcome;
  // all others are checked against the line model below.
  typedef struct {
    logic   mode;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    bit     known;
    bit     known_has;
    pixel_t known_pix;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bls_in_if  in_ch();
  bls_out_if out_ch();

  bresenham_line_stepper u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Line model: tracks the line in progress at the block's own widths.
  // ---------------------------------------------------------------------
  logic     ln_active    = 1'b0;
  logic     ln_steep     = 1'b0;
  logic     ln_maj_down  = 1'b0;
  logic     ln_min_down  = 1'b0;
  coord_t   ln_maj       = '0;
  coord_t   ln_min       = '0;
  coord_t   ln_maj_end   = '0;
  dec_t     ln_decision  = '0;
  str_inc_t ln_straight  = '0;
  dec_t     ln_diagonal  = '0;

  pixel_t expected_pixels[$];

  int mismatches = 0;
  int snd_idle   = 11;   // percent of cycles the sender holds off
  int rcv_idle   = 78;   // percent of cycles the receiver holds off
  int phase      = 0;

  // Advance the line model by one accepted transaction. Returns 1 when the
  // transaction yields a pixel, which is then in pix.
  function automatic bit plot_next(input logic mode, input coord_t x0, input coord_t y0,
                                   input coord_t x1, input coord_t y1, output pixel_t pix);
    coord_t dx;
    coord_t dy;
    coord_t a0;
    coord_t b0;
    coord_t a1;
    coord_t b1;
    coord_t dmaj;
    coord_t dmin;
    logic   fin;
    pix = '0;
    if (mode == MODE_START) begin
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      // steep only when rise strictly exceeds run; 45 degrees stays x-major
      ln_steep = (dy > dx);
      if (ln_steep) begin
        a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end else begin
        a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end
      dmaj = (a1 > a0) ? a1 - a0 : a0 - a1;
      dmin = (b1 > b0) ? b1 - b0 : b0 - b1;
      ln_straight = {1'b0, dmin, 1'b0};
      ln_diagonal = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
      ln_decision = $signed({1'b0, ln_straight}) - $signed({3'b000, dmaj});
      // equal coordinates count as stepping down; harmless, the axis never moves
      ln_maj_down = !(a0 < a1);
      ln_min_down = !(b0 < b1);
      ln_maj      = a0;
      ln_min      = b0;
      ln_maj_end  = a1;
      ln_active   = 1'b1;
      return 1'b0;
    end
    // step with no line in progress is swallowed
    if (!ln_active) return 1'b0;
    fin      = (ln_maj == ln_maj_end);
    pix.x    = ln_steep ? ln_min : ln_maj;
    pix.y    = ln_steep ? ln_maj : ln_min;
    pix.last = fin;
    if (fin) begin
      ln_active = 1'b0;
    end else begin
      if (ln_decision <= 0) begin
        ln_decision = ln_decision + $signed({1'b0, ln_straight});
      end else begin
        ln_min      = ln_min_down ? ln_min - 1'b1 : ln_min + 1'b1;
        ln_decision = ln_decision + ln_diagonal;
      end
      ln_maj = ln_maj_down ? ln_maj - 1'b1 : ln_maj + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t pred_row(input logic mode, input int sx, input int sy,
                                         input int ex, input int ey);
    stim_row_t r;
    r.mode      = mode;
    r.sx        = coord_t'(sx);
    r.sy        = coord_t'(sy);
    r.ex        = coord_t'(ex);
    r.ey        = coord_t'(ey);
    r.known     = 1'b0;
    r.known_has = 1'b0;
    r.known_pix = '0;
    return r;
  endfunction

  // Step row whose outcome is obvious by inspection.
  function automatic stim_row_t known_row(input bit has, input int px, input int py,
                                          input logic last);
    stim_row_t r;
    r           = pred_row(MODE_STEP, 4095, 4095, 4095, 4095);
    r.known     = 1'b1;
    r.known_has = has;
    r.known_pix = '{x: coord_t'(px), y: coord_t'(py), last: last};
    return r;
  endfunction

  // Step row with junk on the endpoint fields, which a step ignores.
  function automatic stim_row_t junk_step();
    return pred_row(MODE_STEP, $urandom_range(4095), $urandom_range(4095),
                    $urandom_range(4095), $urandom_range(4095));
  endfunction

  // Pick a second endpoint within span of the first, kept on screen.
  function automatic int near_coord(input int a, input int span);
    int d;
    int b;
    d = $urandom_range(span);
    b = $urandom_range(1) ? a + d : a - d;
    if (b < 0 || b > 4095) b = 2 * a - b;
    if (b < 0) b = 0;
    if (b > 4095) b = 4095;
    return b;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: random idle cycles, then hold the transaction until taken.
  // counted is set for starts and for steps that give a pixel.
  // ---------------------------------------------------------------------
  task automatic send_item(input stim_row_t r, output bit counted);
    pixel_t pix;
    bit     has;
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= r.mode;
    in_ch.start_x <= r.sx;
    in_ch.start_y <= r.sy;
    in_ch.end_x   <= r.ex;
    in_ch.end_y   <= r.ey;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has = plot_next(r.mode, r.sx, r.sy, r.ex, r.ey, pix);
    counted = (r.mode == MODE_START) || has;
    if (r.known) begin
      has = r.known_has;
      pix = r.known_pix;
    end
    if (has) expected_pixels.push_back(pix);
  endtask

  task automatic note_mismatch(input string what, input int exp_v, input int got_v);
    if (mismatches < 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure; a long hold-off at each phase change
  // so the queue fills and the block stalls its input.
  // ---------------------------------------------------------------------
  int rcv_phase_seen = 0;
  int hold_left      = 0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (phase != rcv_phase_seen) begin
      rcv_phase_seen <= phase;
      hold_left      <= 40 + $urandom_range(40);
      out_ch.ready   <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: each pixel transaction against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch("unexpected pixel, x", -1, out_ch.pixel_x);
      end else begin
        want = expected_pixels.pop_front();
        if (out_ch.pixel_x !== want.x) note_mismatch("pixel_x", want.x, out_ch.pixel_x);
        if (out_ch.pixel_y !== want.y) note_mismatch("pixel_y", want.y, out_ch.pixel_y);
        if (out_ch.last !== want.last) note_mismatch("last", want.last, out_ch.last);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    stim_row_t directed[$];
    stim_row_t r;
    bit        counted;
    int        n_items;
    int        pick;
    int        span;
    int        x0;
    int        y0;
    int        x1;
    int        y1;
    int        len;
    int        nsteps;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_START;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    in_ch.end_x   <= '0;
    in_ch.end_y   <= '0;

    // step straight out of reset: nothing to draw
    directed.push_back(known_row(1'b0, 0, 0, 1'b0));
    // single-point line at the origin, then a step once the line is done
    directed.push_back(pred_row(MODE_START, 0, 0, 0, 0));
    directed.push_back(known_row(1'b1, 0, 0, 1'b1));
    directed.push_back(known_row(1'b0, 0, 0, 1'b0));
    // single-point line at the far corner
    directed.push_back(pred_row(MODE_START, 4095, 4095, 4095, 4095));
    directed.push_back(known_row(1'b1, 4095, 4095, 1'b1));
    // shallow rising line, run to completion
    directed.push_back(pred_row(MODE_START, 0, 0, 3, 1));
    repeat (4) directed.push_back(junk_step());
    // steep line with x stepping down, abandoned halfway
    directed.push_back(pred_row(MODE_START, 4095, 0, 4093, 3));
    repeat (2) directed.push_back(junk_step());
    // exact diagonal (stays x-major), y stepping down, also abandoned
    directed.push_back(pred_row(MODE_START, 10, 4095, 13, 4092));
    repeat (2) directed.push_back(junk_step());
    // vertical line: x delta zero
    directed.push_back(pred_row(MODE_START, 2048, 4095, 2048, 4093));
    repeat (3) directed.push_back(junk_step());
    // horizontal line along the top edge
    directed.push_back(pred_row(MODE_START, 0, 4095, 2, 4095));
    directed.push_back(known_row(1'b1, 0, 4095, 1'b0));
    directed.push_back(known_row(1'b1, 1, 4095, 1'b0));
    directed.push_back(known_row(1'b1, 2, 4095, 1'b1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i], counted);

    // Random part: mostly complete short lines with random content, some
    // longer ones, abandoned lines, idle steps and plain noise.
    n_items = 0;
    while (n_items < 1600) begin
      // three idling phases: sender light / receiver heavy, swapped, none
      phase = 1 + (n_items * 3) / 1600;
      if (phase > 3) phase = 3;
      case (phase)
        1: begin
          snd_idle = 11; rcv_idle = 78;
        end
        2: begin
          snd_idle = 78; rcv_idle = 11;
        end
        default: begin
          snd_idle = 0; rcv_idle = 0;
        end
      endcase

      pick = $urandom_range(99);
      if (pick < 5) begin
        r      = junk_step();
        r.mode = logic'($urandom_range(1));
        send_item(r, counted);
        if (counted) n_items++;
      end else begin
        pick = $urandom_range(99);
        span = (pick < 88) ? 12 : (pick < 98) ? 150 : 4095;
        x0   = $urandom_range(4095);
        y0   = $urandom_range(4095);
        if (span == 4095) begin
          x1 = $urandom_range(4095);
          y1 = $urandom_range(4095);
        end else begin
          x1 = near_coord(x0, span);
          y1 = near_coord(y0, span);
        end
        send_item(pred_row(MODE_START, x0, y0, x1, y1), counted);
        n_items++;
        len = ((x1 > x0) ? x1 - x0 : x0 - x1);
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > len) len = (y1 > y0) ? y1 - y0 : y0 - y1;
        len = len + 1;
        if (span == 4095) begin
          // full-screen lines only get a short run before being replaced
          nsteps = $urandom_range(40);
        end else if ($urandom_range(99) < 15) begin
          nsteps = $urandom_range(len - 1);
        end else begin
          // finish the line, sometimes with idle steps after the last pixel
          nsteps = len + (($urandom_range(99) < 20) ? $urandom_range(2, 1) : 0);
        end
        repeat (nsteps) begin
          send_item(junk_step(), counted);
          if (counted) n_items++;
        end
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then a few more cycles to catch any stray pixel
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bls_pkg.sv
hdl/bls_in_if.sv
hdl/bls_out_if.sv
hdl/bls_front.sv
hdl/bls_queue.sv
hdl/bls_back.sv
hdl/bresenham_line_stepper.sv
dv/tb_top.sv
